FILE: rtl/kpdc_pkg.sv
// Shared types, constants and codes of the key press duration classifier.
package kpdc_pkg;

	localparam int NUM_KEYS    = 5;
	localparam int NUM_COMBOS  = 2;
	localparam int TIMER_BITS  = 16;
	localparam int NUM_TIMERS  = NUM_KEYS + NUM_COMBOS;

	localparam int KEY_FIELD_W = 5;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_ADDR_W  = 2;
	localparam int CODE_W      = 3;

	localparam int KEY_IDX_W   = $clog2(KEY_FIELD_W);
	localparam int TMR_IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CMB_IDX_W   = (NUM_COMBOS > 1) ? $clog2(NUM_COMBOS) : 1;

	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [KEY_FIELD_W-1:0] KEY_MASK = KEY_FIELD_W'((1 << NUM_KEYS) - 1);
	localparam logic [TIMER_BITS-1:0]  TIMER_MAX = {TIMER_BITS{1'b1}};

	localparam logic [TIMER_BITS-1:0] LONG_TICKS_RST  = TIMER_BITS'(2000);
	localparam logic [TIMER_BITS-1:0] VLONG_TICKS_RST = TIMER_BITS'(4000);
	localparam logic [KEY_FIELD_W-1:0] COMBO_A_RST    = KEY_FIELD_W'(3);
	localparam logic [KEY_FIELD_W-1:0] COMBO_B_RST    = KEY_FIELD_W'(5);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_LONG_TICKS  = 2'd0,
		REG_VLONG_TICKS = 2'd1,
		REG_COMBO_A     = 2'd2,
		REG_COMBO_B     = 2'd3
	} reg_idx_t;

	typedef enum logic [CODE_W-1:0] {
		EV_LEAVE = 3'd0,
		EV_ENTER = 3'd1,
		EV_SHORT = 3'd2,
		EV_LONG  = 3'd3,
		EV_VLONG = 3'd4
	} ev_code_t;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic [TIMER_BITS-1:0]                   long_ticks;
		logic [TIMER_BITS-1:0]                   vlong_ticks;
		logic [NUM_COMBOS-1:0][KEY_FIELD_W-1:0]  combo;
	} cfg_t;

	// One classified input item as it waits in the queue.
	typedef struct packed {
		logic                   cmd;
		logic [KEY_FIELD_W-1:0] now;
		logic [KEY_FIELD_W-1:0] chg;
	} item_t;

endpackage

FILE: rtl/key_press_duration_classifier.sv
// Top level of the key press duration classifier: config registers and stream ports.
// Each input beat is a key sample (tuser 0) or a millisecond tick (tuser 1). Input beats are
// taken one per cycle while the four-entry item queue has room; the event sequencer behind it
// handles one item at a time and gives one or more result beats per item, the final one with
// tlast set (an item without events gives a single beat with tuser 0). The sequencer takes an
// item, then visits each key for a sample or each timer (five keys, two combos) for a tick,
// with an extra step for each timer that reaches long and very long on the same tick, and
// then closes the item; a stalled result channel holds it up. Configuration writes take
// effect at once and belong in idle periods.
module key_press_duration_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [kpdc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [kpdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [4:0] key_state, [7:5] zero
	input  logic [0:0]                        s_axis_tuser,  // [0] command
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // [2:0] event_code, [7:3] event_keys
	output logic [0:0]                        m_axis_tuser,  // [0] event_valid
	output logic                              m_axis_tlast
);
	import kpdc_pkg::*;

	cfg_t                   cfg_q;
	logic                   q_push;
	item_t                  q_in;
	logic                   q_full;
	logic                   q_pop;
	item_t                  q_out;
	logic                   q_empty;
	logic                   res_event;
	logic [CODE_W-1:0]      res_code;
	logic [KEY_FIELD_W-1:0] res_keys;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_ticks  <= LONG_TICKS_RST;
			cfg_q.vlong_ticks <= VLONG_TICKS_RST;
			cfg_q.combo[0]    <= COMBO_A_RST;
			cfg_q.combo[1]    <= COMBO_B_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_LONG_TICKS:  cfg_q.long_ticks  <= cfg_wdata[TIMER_BITS-1:0];
				REG_VLONG_TICKS: cfg_q.vlong_ticks <= cfg_wdata[TIMER_BITS-1:0];
				REG_COMBO_A:     cfg_q.combo[0]    <= cfg_wdata[KEY_FIELD_W-1:0];
				REG_COMBO_B:     cfg_q.combo[1]    <= cfg_wdata[KEY_FIELD_W-1:0];
			endcase
		end
	end

	kpdc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_in)
	);

	kpdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	kpdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_event (res_event),
		.res_code  (res_code),
		.res_keys  (res_keys),
		.res_last  (m_axis_tlast)
	);

	assign m_axis_tdata    = {res_keys, res_code};
	assign m_axis_tuser[0] = res_event;

endmodule

FILE: rtl/kpdc_front.sv
// Input side: takes beats, tracks the last key sample and works out changed keys.
module kpdc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [4:0] key_state, rest zero
	input  logic [0:0]                    s_axis_tuser,  // [0] command
	input  logic                          q_full,
	output logic                          q_push,
	output kpdc_pkg::item_t               q_data
);
	import kpdc_pkg::*;

	logic [KEY_FIELD_W-1:0] prev_q;
	logic [KEY_FIELD_W-1:0] now;

	assign now           = s_axis_tdata[KEY_FIELD_W-1:0] & KEY_MASK;
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_data.cmd = s_axis_tuser[0];
		q_data.now = now;
		q_data.chg = (s_axis_tuser[0] == CMD_SAMPLE) ? (now ^ prev_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (q_push && s_axis_tuser[0] == CMD_SAMPLE) begin
			prev_q <= now;
		end
	end

endmodule

FILE: rtl/kpdc_queue.sv
// Small queue between the input side and the event sequencer.
module kpdc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kpdc_pkg::item_t  push_data,
	output logic             full,
	input  logic             pop,
	output kpdc_pkg::item_t  pop_data,
	output logic             empty
);
	import kpdc_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/kpdc_back.sv
// Event sequencer: walks keys or timers of one item, holds timer state, drives results.
module kpdc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kpdc_pkg::cfg_t                cfg,
	input  logic                          q_empty,
	input  kpdc_pkg::item_t               q_data,
	output logic                          q_pop,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          res_event,
	output logic [kpdc_pkg::CODE_W-1:0]   res_code,
	output logic [kpdc_pkg::KEY_FIELD_W-1:0] res_keys,
	output logic                          res_last
);
	import kpdc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                 st_q;
	logic                   cmd_q;
	logic [KEY_FIELD_W-1:0] now_q;
	logic [KEY_FIELD_W-1:0] chg_q;
	logic [TMR_IDX_W-1:0]   idx_q;
	logic                   sub_q;

	logic [TIMER_BITS-1:0]  elapsed_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  long_on_q;
	logic [NUM_TIMERS-1:0]  vlong_on_q;

	// Held event: it goes out once the next one is found or the item closes.
	logic                   pend_valid_q;
	ev_code_t               pend_code_q;
	logic [KEY_FIELD_W-1:0] pend_keys_q;

	logic                   out_valid_q;
	logic                   out_event_q;
	ev_code_t               out_code_q;
	logic [KEY_FIELD_W-1:0] out_keys_q;
	logic                   out_last_q;

	logic [KEY_IDX_W-1:0]   key_idx;
	logic [KEY_FIELD_W-1:0] key_bit;
	logic [TMR_IDX_W-1:0]   cidx_full;
	logic [CMB_IDX_W-1:0]   cidx;
	logic [KEY_FIELD_W-1:0] tmr_keys;
	logic [KEY_FIELD_W-1:0] prev_keys;
	logic [NUM_COMBOS-1:0]  combo_match;
	logic [TIMER_BITS-1:0]  el_cur;
	logic [TIMER_BITS-1:0]  e_next;
	logic                   fire_l;
	logic                   fire_v;

	logic                   ev_fire;
	ev_code_t               ev_code;
	logic [KEY_FIELD_W-1:0] ev_keys;
	logic                   step_last;
	logic                   go_sub;
	logic [NUM_TIMERS-1:0]  long_nx;
	logic [NUM_TIMERS-1:0]  vlong_nx;
	logic                   el_we;
	logic [TIMER_BITS-1:0]  el_wdata;
	logic [NUM_COMBOS-1:0]  cmb_arm;

	logic                   out_free;
	logic                   adv;

	assign out_free  = !out_valid_q || res_ready;
	assign q_pop     = (st_q == ST_IDLE) && !q_empty;

	assign res_valid = out_valid_q;
	assign res_event = out_event_q;
	assign res_code  = out_code_q;
	assign res_keys  = out_keys_q;
	assign res_last  = out_last_q;

	always_comb begin
		key_idx   = idx_q[KEY_IDX_W-1:0];
		key_bit   = KEY_FIELD_W'(1) << key_idx;
		cidx_full = idx_q - TMR_IDX_W'(NUM_KEYS);
		cidx      = cidx_full[CMB_IDX_W-1:0];
		tmr_keys  = (idx_q < TMR_IDX_W'(NUM_KEYS)) ? key_bit : cfg.combo[cidx];
		prev_keys = now_q ^ chg_q;
		for (int c = 0; c < NUM_COMBOS; c++) begin
			combo_match[c] = (now_q == cfg.combo[c]);
		end
		el_cur = elapsed_q[idx_q];
		e_next = (el_cur == TIMER_MAX) ? el_cur : el_cur + TIMER_BITS'(1);
		fire_l = long_on_q[idx_q] && (e_next >= cfg.long_ticks);
		fire_v = vlong_on_q[idx_q] && (e_next >= cfg.vlong_ticks);

		ev_fire   = 1'b0;
		ev_code   = EV_LEAVE;
		ev_keys   = '0;
		step_last = 1'b0;
		go_sub    = 1'b0;
		long_nx   = long_on_q;
		vlong_nx  = vlong_on_q;
		el_we     = 1'b0;
		el_wdata  = e_next;
		cmb_arm   = '0;

		if (cmd_q == CMD_SAMPLE) begin
			step_last = (idx_q == TMR_IDX_W'(NUM_KEYS - 1));
			if (chg_q[key_idx]) begin
				ev_fire = 1'b1;
				if (now_q[key_idx]) begin
					ev_code = EV_ENTER;
					ev_keys = now_q;
					if (now_q == key_bit) begin
						el_we           = 1'b1;
						el_wdata        = '0;
						long_nx[idx_q]  = 1'b1;
						vlong_nx[idx_q] = 1'b1;
					end else begin
						// Multi-key press: drop the old keys, rearm matching combos.
						for (int i = 0; i < NUM_KEYS; i++) begin
							if (prev_keys[i]) begin
								long_nx[i]  = 1'b0;
								vlong_nx[i] = 1'b0;
							end
						end
						for (int c = 0; c < NUM_COMBOS; c++) begin
							long_nx[NUM_KEYS+c]  = combo_match[c];
							vlong_nx[NUM_KEYS+c] = combo_match[c];
						end
						cmb_arm = combo_match;
					end
				end else begin
					ev_code = long_on_q[idx_q] ? EV_SHORT : EV_LEAVE;
					ev_keys = chg_q;
					long_nx[idx_q]  = 1'b0;
					vlong_nx[idx_q] = 1'b0;
					for (int c = 0; c < NUM_COMBOS; c++) begin
						long_nx[NUM_KEYS+c]  = 1'b0;
						vlong_nx[NUM_KEYS+c] = 1'b0;
					end
				end
			end
		end else if (!sub_q) begin
			if (long_on_q[idx_q] || vlong_on_q[idx_q]) begin
				el_we   = 1'b1;
				ev_fire = fire_l || fire_v;
				ev_code = fire_l ? EV_LONG : EV_VLONG;
				ev_keys = tmr_keys;
				if (fire_l) begin
					long_nx[idx_q] = 1'b0;
				end
				if (fire_v) begin
					vlong_nx[idx_q] = 1'b0;
				end
				// Both expire on the same tick: very long follows in an extra sub step.
				go_sub = fire_l && fire_v;
			end
			step_last = !go_sub && (idx_q == TMR_IDX_W'(NUM_TIMERS - 1));
		end else begin
			ev_fire   = 1'b1;
			ev_code   = EV_VLONG;
			ev_keys   = tmr_keys;
			step_last = (idx_q == TMR_IDX_W'(NUM_TIMERS - 1));
		end

		unique case (st_q)
			ST_RUN:  adv = !(ev_fire && pend_valid_q) || out_free;
			ST_DONE: adv = out_free;
			default: adv = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			cmd_q        <= CMD_SAMPLE;
			now_q        <= '0;
			chg_q        <= '0;
			idx_q        <= '0;
			sub_q        <= 1'b0;
			long_on_q    <= '0;
			vlong_on_q   <= '0;
			for (int t = 0; t < NUM_TIMERS; t++) begin
				elapsed_q[t] <= '0;
			end
			pend_valid_q <= 1'b0;
			pend_code_q  <= EV_LEAVE;
			pend_keys_q  <= '0;
			out_valid_q  <= 1'b0;
			out_event_q  <= 1'b0;
			out_code_q   <= EV_LEAVE;
			out_keys_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cmd_q <= q_data.cmd;
						now_q <= q_data.now;
						chg_q <= q_data.chg;
						idx_q <= '0;
						sub_q <= 1'b0;
						st_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv) begin
						long_on_q  <= long_nx;
						vlong_on_q <= vlong_nx;
						if (el_we) begin
							elapsed_q[idx_q] <= el_wdata;
						end
						for (int c = 0; c < NUM_COMBOS; c++) begin
							if (cmb_arm[c]) begin
								elapsed_q[NUM_KEYS+c] <= '0;
							end
						end
						if (ev_fire) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_event_q <= 1'b1;
								out_code_q  <= pend_code_q;
								out_keys_q  <= pend_keys_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_code_q  <= ev_code;
							pend_keys_q  <= ev_keys;
						end
						if (step_last) begin
							sub_q <= 1'b0;
							st_q  <= ST_DONE;
						end else if (go_sub) begin
							sub_q <= 1'b1;
						end else begin
							sub_q <= 1'b0;
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (adv) begin
						out_valid_q  <= 1'b1;
						out_event_q  <= pend_valid_q;
						out_code_q   <= pend_valid_q ? pend_code_q : EV_LEAVE;
						out_keys_q   <= pend_valid_q ? pend_keys_q : '0;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						st_q         <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held event left over between items");

	a_sub_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (cmd_q == CMD_TICK && st_q != ST_IDLE))
		else $error("second timer event phase outside a tick");

	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && adv) |=> (out_valid_q && out_last_q))
		else $error("item closed without a last result");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> (idx_q < TMR_IDX_W'(NUM_TIMERS)))
		else $error("timer index out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_ready) |=> out_valid_q)
		else $error("pending result dropped");

endmodule

FILE: bench/tb.sv
// Stream testbench for the key press duration classifier, with its own event predictor.
`timescale 1ns / 1ps

module tb;
	import kpdc_pkg::*;

	typedef struct {
		logic                   cmd;
		logic [KEY_FIELD_W-1:0] keys;
	} key_beat_t;

	typedef struct {
		logic                   vld;
		ev_code_t               code;
		logic [KEY_FIELD_W-1:0] keys;
		logic                   last;
	} key_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;   // [4:0] key_state, [7:5] zero
	logic [0:0]            s_axis_tuser = '0;   // [0] command
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;        // [2:0] event_code, [7:3] event_keys
	logic [0:0]            m_axis_tuser;        // [0] event_valid
	logic                  m_axis_tlast;

	key_press_duration_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Predictor state: timers 0..NUM_KEYS-1 belong to keys, the rest to combos.
	logic [TIMER_BITS-1:0]  long_thr;
	logic [TIMER_BITS-1:0]  vlong_thr;
	logic [KEY_FIELD_W-1:0] combo_key [NUM_COMBOS];
	logic [KEY_FIELD_W-1:0] held_keys;
	logic [TIMER_BITS-1:0]  tmr_cnt   [NUM_TIMERS];
	logic                   tmr_long  [NUM_TIMERS];
	logic                   tmr_vlong [NUM_TIMERS];

	key_beat_t  stim_q [$];
	key_event_t step_ev [$];
	key_event_t event_q [$];

	int  sent_cnt = 0;
	int  taken_cnt = 0;
	int  n_bad = 0;
	logic in_acc = 1'b0;
	bit  calm = 1'b0;
	bit  hold_ask = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  src_gap = 0;
	int  snk_gap = 0;

	task automatic add_event(ev_code_t code, logic [KEY_FIELD_W-1:0] keys);
		step_ev.push_back('{1'b1, code, keys, 1'b0});
	endtask

	task automatic tmr_arm(int t);
		tmr_cnt[t] = '0;
		tmr_long[t] = 1'b1;
		tmr_vlong[t] = 1'b1;
	endtask

	task automatic tmr_stop(int t);
		tmr_long[t] = 1'b0;
		tmr_vlong[t] = 1'b0;
	endtask

	task automatic tmr_tick(int t, logic [KEY_FIELD_W-1:0] keys);
		if (tmr_long[t] || tmr_vlong[t]) begin
			if (tmr_cnt[t] != TIMER_MAX)
				tmr_cnt[t] = tmr_cnt[t] + 1'b1;
			if (tmr_long[t] && tmr_cnt[t] >= long_thr) begin
				tmr_long[t] = 1'b0;
				add_event(EV_LONG, keys);
			end
			if (tmr_vlong[t] && tmr_cnt[t] >= vlong_thr) begin
				tmr_vlong[t] = 1'b0;
				add_event(EV_VLONG, keys);
			end
		end
	endtask

	// Work out the events of one accepted beat and queue them for the checker.
	task automatic classify_beat(logic cmd, logic [KEY_FIELD_W-1:0] raw);
		logic [KEY_FIELD_W-1:0] now_k;
		logic [KEY_FIELD_W-1:0] chg;
		logic                   short_rel;
		step_ev.delete();
		if (cmd == CMD_SAMPLE) begin
			now_k = raw & KEY_MASK;
			chg = now_k ^ held_keys;
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (chg[k]) begin
					if (now_k[k]) begin
						if (now_k == KEY_FIELD_W'(1 << k)) begin
							tmr_arm(k);
						end else begin
							for (int i = 0; i < NUM_KEYS; i++)
								if (held_keys[i])
									tmr_stop(i);
							for (int c = 0; c < NUM_COMBOS; c++)
								tmr_stop(NUM_KEYS + c);
							for (int c = 0; c < NUM_COMBOS; c++)
								if (now_k == combo_key[c])
									tmr_arm(NUM_KEYS + c);
						end
						add_event(EV_ENTER, now_k);
					end else begin
						short_rel = tmr_long[k];
						tmr_stop(k);
						for (int c = 0; c < NUM_COMBOS; c++)
							tmr_stop(NUM_KEYS + c);
						add_event(short_rel ? EV_SHORT : EV_LEAVE, chg);
					end
				end
			end
			held_keys = now_k;
		end else begin
			for (int k = 0; k < NUM_KEYS; k++)
				tmr_tick(k, KEY_FIELD_W'(1 << k));
			for (int c = 0; c < NUM_COMBOS; c++)
				tmr_tick(NUM_KEYS + c, combo_key[c]);
		end
		if (step_ev.size() == 0)
			step_ev.push_back('{1'b0, EV_LEAVE, '0, 1'b0});
		step_ev[step_ev.size() - 1].last = 1'b1;
		foreach (step_ev[i])
			event_q.push_back(step_ev[i]);
	endtask

	// Input side: hold a beat until taken, insert short idle bursts.
	always @(negedge clk) begin : drive_in
		key_beat_t b;
		if (!(s_axis_tvalid && !in_acc)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(0, 2);
				s_axis_tvalid <= 1'b0;
			end else if (stim_q.size() != 0) begin
				b = stim_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {3'b000, b.keys};
				s_axis_tuser <= b.cmd;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result side: one long hold on request, otherwise short random stalls.
	always @(negedge clk) begin : drive_out
		if (hold_ask && !hold_done) begin
			hold_left = 300;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			snk_gap = $urandom_range(0, 2);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch
		key_event_t e;
		if (arst_n) begin
			in_acc <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				classify_beat(s_axis_tuser[0], s_axis_tdata[KEY_FIELD_W-1:0]);
				taken_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (event_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: result beat with nothing expected: valid %0b code %0d keys %b last %0b",
							$realtime, m_axis_tuser[0], m_axis_tdata[2:0], m_axis_tdata[7:3],
							m_axis_tlast);
				end else begin
					e = event_q.pop_front();
					if (e.vld !== m_axis_tuser[0] || e.code !== m_axis_tdata[2:0] ||
					    e.keys !== m_axis_tdata[7:3] || e.last !== m_axis_tlast) begin
						n_bad++;
						if (n_bad <= 10)
							$display("%0t: mismatch: expected valid %0b code %0d keys %b last %0b, got valid %0b code %0d keys %b last %0b",
								$realtime, e.vld, e.code, e.keys, e.last, m_axis_tuser[0],
								m_axis_tdata[2:0], m_axis_tdata[7:3], m_axis_tlast);
					end
				end
			end
		end
	end

	task automatic push_item(logic cmd, logic [KEY_FIELD_W-1:0] keys);
		stim_q.push_back('{cmd, keys});
		sent_cnt++;
	endtask

	task automatic set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_LONG_TICKS:  long_thr = val;
			REG_VLONG_TICKS: vlong_thr = val;
			REG_COMBO_A:     combo_key[0] = val[KEY_FIELD_W-1:0];
			REG_COMBO_B:     combo_key[1] = val[KEY_FIELD_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
	endtask

	// Combo writes carry random upper bits that the block must drop.
	task automatic configure(logic [15:0] lt, logic [15:0] vt, logic [4:0] ca, logic [4:0] cb);
		set_reg(REG_LONG_TICKS, lt);
		set_reg(REG_VLONG_TICKS, vt);
		set_reg(REG_COMBO_A, (16'($urandom_range(0, 2047)) << 5) | 16'(ca));
		set_reg(REG_COMBO_B, (16'($urandom_range(0, 2047)) << 5) | 16'(cb));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (taken_cnt != sent_cnt || event_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Press sessions: a key sample followed by a run of ticks, with some noise samples.
	task automatic add_random(int n);
		int                     cnt;
		int                     ticks;
		logic [KEY_FIELD_W-1:0] m;
		cnt = 0;
		m = '0;
		while (cnt < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: m = KEY_FIELD_W'(1 << $urandom_range(0, NUM_KEYS - 1));
				4, 5:       m = combo_key[$urandom_range(0, NUM_COMBOS - 1)];
				6:          m = KEY_FIELD_W'($urandom_range(0, 31));
				7:          m = m | KEY_FIELD_W'(1 << $urandom_range(0, NUM_KEYS - 1));
				default:    m = '0;
			endcase
			push_item(CMD_SAMPLE, m);
			cnt++;
			ticks = $urandom_range(0, 10);
			repeat (ticks)
				push_item(CMD_TICK, KEY_FIELD_W'($urandom_range(0, 31)));
			cnt += ticks;
		end
	endtask

	initial begin : run_stimulus
		long_thr = LONG_TICKS_RST;
		vlong_thr = VLONG_TICKS_RST;
		combo_key[0] = COMBO_A_RST;
		combo_key[1] = COMBO_B_RST;
		held_keys = '0;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			tmr_cnt[t] = '0;
			tmr_long[t] = 1'b0;
			tmr_vlong[t] = 1'b0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (5) @(negedge clk);

		// Reset settings first.
		add_random(20);
		wait_drained();

		configure(16'd2, 16'd4, 5'd3, 5'd5);
		push_item(CMD_SAMPLE, 5'b00001);
		repeat (4) push_item(CMD_TICK, 5'b00000);
		push_item(CMD_SAMPLE, 5'b00000);    // leave after long and very long
		push_item(CMD_SAMPLE, 5'b00001);
		push_item(CMD_SAMPLE, 5'b00000);    // short press
		push_item(CMD_SAMPLE, 5'b00011);    // combo A, two keys at once
		repeat (4) push_item(CMD_TICK, 5'b11111);
		push_item(CMD_SAMPLE, 5'b00101);    // release into combo B
		push_item(CMD_TICK, 5'b00000);
		push_item(CMD_SAMPLE, 5'b11111);
		push_item(CMD_SAMPLE, 5'b00000);
		push_item(CMD_SAMPLE, 5'b10000);
		push_item(CMD_SAMPLE, 5'b11000);    // second key disarms the lone key
		push_item(CMD_TICK, 5'b00000);
		push_item(CMD_SAMPLE, 5'b01000);
		push_item(CMD_SAMPLE, 5'b00000);
		wait_drained();

		configure(16'd1, 16'd1, 5'd3, 5'd5);
		add_random(40);
		wait_drained();

		configure(16'd1, 16'hFFFF, 5'd31, 5'd0);
		add_random(40);
		wait_drained();

		// Equal combos; stall the result side long enough to back up the input.
		configure(16'hFFFF, 16'd2, 5'd6, 5'd6);
		hold_ask = 1'b1;
		add_random(45);
		wait_drained();

		configure(16'd3, 16'd7, 5'd4, 5'd24);
		add_random(40);
		wait_drained();

		configure(16'd5, 16'd3, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
		add_random(40);
		wait_drained();

		repeat (2) begin
			configure(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
				5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			add_random(40);
			wait_drained();
		end

		calm = 1'b1;
		configure(16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)), 5'd7, 5'd28);
		add_random(35);

		for (int w = 0; w < 50000 && (taken_cnt != sent_cnt || event_q.size() != 0); w++)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (n_bad == 0 && event_q.size() == 0 && taken_cnt == sent_cnt)
			$display("key_press_duration_classifier test passed");
		else
			$display("key_press_duration_classifier test failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("key_press_duration_classifier test failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/kpdc_pkg.sv
rtl/kpdc_front.sv
rtl/kpdc_queue.sv
rtl/kpdc_back.sv
rtl/key_press_duration_classifier.sv
bench/tb.sv
